// File: sv/tlbclk_pkg.sv
// Package for the fully associative TLB with second-chance replacement.
// Holds sizes, the request and response beat types, the controller state type
// and the controller command type. Depends on nothing.
package tlbclk_pkg;

   localparam int ENTRIES   = 16;
   localparam int PAGE_BITS = 20;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);

   localparam int VPN_W     = 20;
   localparam int FRAME_W   = 20;
   localparam int SLOT_W    = 4;
   localparam int HITS_W    = 32;
   localparam int CFG_W     = 5;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic CSR_IDX_ENTRIES = 1'b0;
   localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(16);

   typedef struct packed {
      logic [VPN_W-1:0]   virt_page;
      logic               is_write;
      logic [FRAME_W-1:0] walk_frame;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic               dirty_out;
      logic [HITS_W-1:0]  hits_so_far;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic load_req;
      logic commit;
   } cmd_type;

endpackage

// File: sv/tlbclk_csr.sv
// Configuration register block for the TLB: holds entries_in_use.
// Uses tlbclk_pkg for widths and the register index.
module tlbclk_csr
   import tlbclk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [CFG_W-1:0]      entries_in_use
);

   logic [CFG_W-1:0] entries_ff;
   logic [CFG_W-1:0] entries_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      entries_in = entries_ff;
      if (wr_en && paddr[2] == CSR_IDX_ENTRIES) begin
         entries_in = pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
      end else begin
         entries_ff <= entries_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_ENTRIES) begin
         prdata = CSR_DATA_W'(entries_ff);
      end
   end

   assign entries_in_use = entries_ff;

endmodule

// File: sv/tlbclk_ctrl.sv
// Controller state machine for the TLB: accepts a request, runs the lookup
// state and strobes the response. Uses tlbclk_pkg for the state and command types.
module tlbclk_ctrl
   import tlbclk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd,
   output logic    rsp_valid
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.commit;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.commit   = 1'b0;
      busy         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            busy       = 1'b1;
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/tlbclk_dp.sv
// Datapath for the TLB: entry store, parallel match, victim pick, hit counter
// and response register. Uses tlbclk_pkg; driven by commands from tlbclk_ctrl.
module tlbclk_dp
   import tlbclk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  req_type          req_data,
   input  logic [CFG_W-1:0] entries_in_use,
   output rsp_type          rsp_data
);

   logic [PAGE_BITS-1:0] page_ff  [ENTRIES];
   logic [PAGE_BITS-1:0] frame_ff [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff;
   logic [ENTRIES-1:0]   used_ff;
   logic [ENTRIES-1:0]   dirty_ff;
   logic [ENTRIES-1:0]   used_in;
   logic [HITS_W-1:0]    hits_ff;
   logic [HITS_W-1:0]    hits_in;
   req_type              req_ff;
   rsp_type              rsp_ff;

   logic [CNT_W-1:0]     n_eff;
   logic [ENTRIES-1:0]   active;
   logic [ENTRIES-1:0]   match;
   logic [ENTRIES-1:0]   free;
   logic [ENTRIES-1:0]   unused;
   logic [ENTRIES-1:0]   clear_mask;
   logic [IDX_W-1:0]     hit_idx;
   logic [IDX_W-1:0]     free_idx;
   logic [IDX_W-1:0]     unused_idx;
   logic [IDX_W-1:0]     slot;
   logic [PAGE_BITS-1:0] req_page;
   logic [PAGE_BITS-1:0] out_frame;
   logic                 hit;
   logic                 dirty_new;

   function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   assign req_page = PAGE_BITS'(req_ff.virt_page);

   always_comb begin
      if (entries_in_use == '0) begin
         n_eff = CNT_W'(1);
      end else if (int'(entries_in_use) > ENTRIES) begin
         n_eff = CNT_W'(ENTRIES);
      end else begin
         n_eff = CNT_W'(entries_in_use);
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         active[i] = CNT_W'(i) < n_eff;
         match[i]  = active[i] & valid_ff[i] & (page_ff[i] == req_page);
         free[i]   = active[i] & ~valid_ff[i];
         unused[i] = active[i] & ~used_ff[i];
      end
   end

   assign hit        = |match;
   assign hit_idx    = first_set(match);
   assign free_idx   = first_set(free);
   assign unused_idx = first_set(unused);

   always_comb begin
      clear_mask = '0;
      slot       = '0;
      if (hit) begin
         slot = hit_idx;
      end else if (|free) begin
         slot = free_idx;
      end else if (|unused) begin
         slot = unused_idx;
         for (int i = 0; i < ENTRIES; i++) begin
            clear_mask[i] = active[i] & (IDX_W'(i) < unused_idx);
         end
      end else begin
         clear_mask = active;
      end
   end

   always_comb begin
      used_in       = used_ff & ~clear_mask;
      used_in[slot] = 1'b1;
   end

   assign dirty_new = hit ? (dirty_ff[slot] | req_ff.is_write) : req_ff.is_write;
   assign out_frame = hit ? frame_ff[slot] : PAGE_BITS'(req_ff.walk_frame);
   assign hits_in   = hits_ff + HITS_W'(hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         dirty_ff <= '0;
         hits_ff  <= '0;
      end else if (cmd.commit) begin
         valid_ff[slot] <= 1'b1;
         used_ff        <= used_in;
         dirty_ff[slot] <= dirty_new;
         hits_ff        <= hits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         if (!hit) begin
            page_ff[slot]  <= req_page;
            frame_ff[slot] <= out_frame;
         end
         rsp_ff.frame       <= FRAME_W'(out_frame);
         rsp_ff.hit         <= hit;
         rsp_ff.slot        <= SLOT_W'(slot);
         rsp_ff.dirty_out   <= dirty_new;
         rsp_ff.hits_so_far <= hits_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: sv/tlb_lookup_clock_replace_top.sv
// Fully associative TLB with second-chance replacement, top level.
// A request is captured when accepted in the idle state; the lookup state then matches,
// picks and updates the entries and loads the response register, and the strobe is
// registered from that commit. No new request is taken until the lookup state is done.
// Reset clears all valid, used and dirty bits and the hit counter and sets
// entries_in_use to 16; results are strobed once and the receiver cannot stall.
module tlb_lookup_clock_replace_top
   import tlbclk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cmd_type          cmd;
   logic [CFG_W-1:0] entries_in_use;

   tlbclk_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .entries_in_use (entries_in_use)
   );

   tlbclk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   tlbclk_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_data       (req_data),
      .entries_in_use (entries_in_use),
      .rsp_data       (rsp_data)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not enter lookup");

   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("lookup cycle not followed by a result strobe");

   a_strobe_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_miss_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.frame == $past(req_data.walk_frame, 2)))
      else $error("miss did not return the walk frame");

endmodule
